FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the island counter.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion that also holds while reset is high.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

FILE: rtl/core/oic_pkg.sv
// ---------------------------------------------------------------------------
// oic_pkg
// Types and constants shared by the island counter modules.
// ---------------------------------------------------------------------------
`default_nettype none

package oic_pkg;

   localparam int MAX_ROWS  = 64;
   localparam int MAX_COLS  = 64;
   localparam int CELLS     = MAX_ROWS * MAX_COLS;
   localparam int IDX_W     = $clog2(CELLS);
   localparam int ROW_W     = 6;
   localparam int COL_W     = 6;
   localparam int CFG_W     = 7;
   localparam int CNT_W     = 12;
   localparam int RANK_W    = 4;
   localparam int REQ_W     = 16;
   localparam int RSP_W     = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_COLS = 1'd1;

   // neighbor visiting order
   localparam logic [1:0] DIR_RIGHT = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_UP    = 2'd3;
   localparam logic [2:0] DIR_COUNT = 3'd4;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_CLEAR,
      CMD_ACCEPT,
      CMD_RD_LAND_HERE,
      CMD_MARK,
      CMD_NEXT_K,
      CMD_RD_LAND_NBR,
      CMD_FIND_A,
      CMD_FIND_B,
      CMD_RD_PARENT_CUR,
      CMD_FOLLOW,
      CMD_SET_TOP,
      CMD_RD_PARENT_WALK,
      CMD_COMPRESS,
      CMD_RD_RANK_A,
      CMD_RD_RANK_B,
      CMD_UNITE,
      CMD_RESULT
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic bad;
      logic land;
      logic k_end;
      logic nbr_ok;
      logic parent_self;
      logic walk_at_top;
      logic roots_equal;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/core/oic_ctrl.sv
// ---------------------------------------------------------------------------
// oic_ctrl
// Sequencer for one query: land check, neighbor scan, two finds, union.
// ---------------------------------------------------------------------------
`default_nettype none

module oic_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   input  oic_pkg::status_type status,
   output oic_pkg::cmd_type    cmd
);
   import oic_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_CHECK, S_LAND, S_NBR, S_NBR_LAND, S_FRD, S_FCHK,
      S_CRD, S_CWR, S_ROOTS, S_RKB, S_UNITE, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      second_ff, second_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      second_in = second_ff;
      cmd       = CMD_NONE;
      unique case (state_ff)
         S_CLEAR: begin
            cmd = CMD_CLEAR;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd      = CMD_ACCEPT;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.bad) begin
               state_in = S_DONE;
            end else begin
               cmd      = CMD_RD_LAND_HERE;
               state_in = S_LAND;
            end
         end
         S_LAND: begin
            if (status.land) begin
               state_in = S_DONE;
            end else begin
               cmd      = CMD_MARK;
               state_in = S_NBR;
            end
         end
         S_NBR: begin
            if (status.k_end) begin
               state_in = S_DONE;
            end else if (!status.nbr_ok) begin
               cmd = CMD_NEXT_K;
            end else begin
               cmd      = CMD_RD_LAND_NBR;
               state_in = S_NBR_LAND;
            end
         end
         S_NBR_LAND: begin
            if (!status.land) begin
               cmd      = CMD_NEXT_K;
               state_in = S_NBR;
            end else begin
               cmd       = CMD_FIND_A;
               second_in = 1'b0;
               state_in  = S_FRD;
            end
         end
         S_FRD: begin
            cmd      = CMD_RD_PARENT_CUR;
            state_in = S_FCHK;
         end
         S_FCHK: begin
            if (status.parent_self) begin
               cmd      = CMD_SET_TOP;
               state_in = S_CRD;
            end else begin
               cmd      = CMD_FOLLOW;
               state_in = S_FRD;
            end
         end
         S_CRD: begin
            if (!status.walk_at_top) begin
               cmd      = CMD_RD_PARENT_WALK;
               state_in = S_CWR;
            end else if (!second_ff) begin
               cmd       = CMD_FIND_B;
               second_in = 1'b1;
               state_in  = S_FRD;
            end else begin
               state_in = S_ROOTS;
            end
         end
         S_CWR: begin
            cmd      = CMD_COMPRESS;
            state_in = S_CRD;
         end
         S_ROOTS: begin
            if (status.roots_equal) begin
               cmd      = CMD_NEXT_K;
               state_in = S_NBR;
            end else begin
               cmd      = CMD_RD_RANK_A;
               state_in = S_RKB;
            end
         end
         S_RKB: begin
            cmd      = CMD_RD_RANK_B;
            state_in = S_UNITE;
         end
         S_UNITE: begin
            cmd      = CMD_UNITE;
            state_in = S_NBR;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd      = CMD_RESULT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         second_ff <= second_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/oic_dp.sv
// ---------------------------------------------------------------------------
// oic_dp
// Grid registers, land/parent/rank memories, walk registers and result slot.
// ---------------------------------------------------------------------------
`default_nettype none

module oic_dp (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_we,
   input  wire [oic_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire [oic_pkg::CFG_W-1:0]     csr_wdata,
   input  wire [oic_pkg::REQ_W-1:0]     req_tdata,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [oic_pkg::RSP_W-1:0]    rsp_tdata,
   input  oic_pkg::cmd_type             cmd,
   output oic_pkg::status_type          status
);
   import oic_pkg::*;

   logic [CFG_W-1:0]  rows_ff, cols_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [COL_W-1:0]  col_ff;
   logic [IDX_W-1:0]  here_ff, there_ff, start_ff, cur_ff, walk_ff, top_ff, ra_ff, clr_ff;
   logic [2:0]        k_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [RANK_W-1:0] rank_a_ff;
   logic              rsp_valid_ff;
   logic [CNT_W-1:0]  rsp_count_ff;
   logic              rsp_bad_ff;

   logic              land_mem [CELLS];
   logic [IDX_W-1:0]  parent_mem [CELLS];
   logic [RANK_W-1:0] rank_mem [CELLS];
   logic              land_q;
   logic [IDX_W-1:0]  parent_q;
   logic [RANK_W-1:0] rank_q;

   logic [CFG_W-1:0]  rows_eff, cols_eff;
   logic [IDX_W-1:0]  here_c, nbr_idx;
   logic              bad_c, nbr_ok;

   assign rows_eff = (rows_ff > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : rows_ff;
   assign cols_eff = (cols_ff > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : cols_ff;
   assign bad_c    = ({1'b0, row_ff} >= rows_eff) || ({1'b0, col_ff} >= cols_eff);
   assign here_c   = IDX_W'(row_ff) * IDX_W'(cols_eff) + IDX_W'(col_ff);

   always_comb begin
      nbr_ok  = 1'b0;
      nbr_idx = here_ff;
      case (k_ff[1:0])
         DIR_RIGHT: begin
            nbr_ok  = ({1'b0, col_ff} + CFG_W'(1)) < cols_eff;
            nbr_idx = here_ff + IDX_W'(1);
         end
         DIR_DOWN: begin
            nbr_ok  = ({1'b0, row_ff} + CFG_W'(1)) < rows_eff;
            nbr_idx = here_ff + IDX_W'(cols_eff);
         end
         DIR_LEFT: begin
            nbr_ok  = (col_ff != '0);
            nbr_idx = here_ff - IDX_W'(1);
         end
         default: begin
            nbr_ok  = (row_ff != '0);
            nbr_idx = here_ff - IDX_W'(cols_eff);
         end
      endcase
   end

   assign status.clear_last  = (clr_ff == IDX_W'(CELLS - 1));
   assign status.bad         = bad_c;
   assign status.land        = land_q;
   assign status.k_end       = (k_ff == DIR_COUNT);
   assign status.nbr_ok      = nbr_ok;
   assign status.parent_self = (parent_q == cur_ff);
   assign status.walk_at_top = (walk_ff == top_ff);
   assign status.roots_equal = (ra_ff == top_ff);
   assign status.out_free    = !rsp_valid_ff || rsp_tready;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= CFG_W'(64);
         cols_ff <= CFG_W'(64);
      end else if (csr_we) begin
         if (csr_index == REG_GRID_ROWS) rows_ff <= csr_wdata;
         if (csr_index == REG_GRID_COLS) cols_ff <= csr_wdata;
      end
   end

   // land map
   always_ff @(posedge clock) begin
      if (cmd == CMD_CLEAR) land_mem[clr_ff] <= 1'b0;
      else if (cmd == CMD_MARK) land_mem[here_ff] <= 1'b1;
      land_q <= land_mem[(cmd == CMD_RD_LAND_HERE) ? here_c : nbr_idx];
   end

   // parent links
   always_ff @(posedge clock) begin
      if (cmd == CMD_CLEAR) begin
         parent_mem[clr_ff] <= clr_ff;
      end else if (cmd == CMD_COMPRESS) begin
         parent_mem[walk_ff] <= top_ff;
      end else if (cmd == CMD_UNITE) begin
         if (rank_q > rank_a_ff) parent_mem[ra_ff] <= top_ff;
         else                    parent_mem[top_ff] <= ra_ff;
      end
      parent_q <= parent_mem[(cmd == CMD_RD_PARENT_CUR) ? cur_ff : walk_ff];
   end

   // ranks
   always_ff @(posedge clock) begin
      if (cmd == CMD_CLEAR) begin
         rank_mem[clr_ff] <= RANK_W'(1);
      end else if (cmd == CMD_UNITE && rank_q == rank_a_ff && rank_a_ff != '1) begin
         rank_mem[ra_ff] <= rank_a_ff + RANK_W'(1);
      end
      rank_q <= rank_mem[(cmd == CMD_RD_RANK_A) ? ra_ff : top_ff];
   end

   // walk registers
   always_ff @(posedge clock) begin
      case (cmd)
         CMD_ACCEPT: begin
            row_ff <= req_tdata[ROW_W-1:0];
            col_ff <= req_tdata[ROW_W+COL_W-1:ROW_W];
         end
         CMD_RD_LAND_HERE: here_ff <= here_c;
         CMD_RD_LAND_NBR:  there_ff <= nbr_idx;
         CMD_FIND_A: begin
            start_ff <= here_ff;
            cur_ff   <= here_ff;
         end
         CMD_FIND_B: begin
            ra_ff    <= top_ff;
            start_ff <= there_ff;
            cur_ff   <= there_ff;
         end
         CMD_FOLLOW: cur_ff <= parent_q;
         CMD_SET_TOP: begin
            top_ff  <= cur_ff;
            walk_ff <= start_ff;
         end
         CMD_COMPRESS:  walk_ff <= parent_q;
         CMD_RD_RANK_B: rank_a_ff <= rank_q;
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         k_ff         <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd == CMD_CLEAR) clr_ff <= clr_ff + IDX_W'(1);
         if (cmd == CMD_MARK) begin
            k_ff <= '0;
            if (count_ff != '1) count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd == CMD_NEXT_K) k_ff <= k_ff + 3'd1;
         if (cmd == CMD_UNITE) begin
            k_ff <= k_ff + 3'd1;
            if (count_ff != '0) count_ff <= count_ff - CNT_W'(1);
         end
         if (cmd == CMD_RESULT) begin
            rsp_valid_ff <= 1'b1;
            rsp_count_ff <= count_ff;
            rsp_bad_ff   <= bad_c;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-CNT_W-1){1'b0}}, rsp_bad_ff, rsp_count_ff};

endmodule

`default_nettype wire

FILE: rtl/core/online_island_count_union_find.sv
// ---------------------------------------------------------------------------
// online_island_count_union_find
// Online island counter over a configurable grid using union-find.
// ---------------------------------------------------------------------------
// Usage:
//   Write grid_rows (index 0) and grid_cols (index 1) on the csr port while
//   idle. Each req transaction names one cell that turns to land and returns
//   one rsp transaction with the island count and an out-of-grid flag.
//   One query at a time: req_tready is high only when the sequencer is idle.
//   A bad coordinate is answered without touching the memories, and a cell
//   that is already land after its land read. A new cell reads the land
//   bit of each in-grid neighbor and skips out-of-grid ones, then ends
//   with the end check and result. Each land neighbor adds two finds over
//   the parent memory: a walk up the tree and a pass that compresses the
//   walked links, then a root compare, and rank reads and a union when the
//   roots differ. The parent memory has a single read port.
//   After reset the block sweeps all 4096 cells; req_tready stays low
//   during the sweep, csr writes are taken.
//   A stalled rsp holds its data; the block may take the next req meanwhile,
//   but finishes it only once the held result has left.
// ---------------------------------------------------------------------------
`default_nettype none

module online_island_count_union_find (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_we,
   input  wire [oic_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire [oic_pkg::CFG_W-1:0]     csr_wdata,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   // [5:0] row_index, [11:6] col_index, [15:12] zero
   input  wire [oic_pkg::REQ_W-1:0]     req_tdata,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   // [11:0] island_count, [12] bad_coord, [15:13] zero
   output logic [oic_pkg::RSP_W-1:0]    rsp_tdata
);
   import oic_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: one command per cycle into the datapath
   oic_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: memories, walk registers, count and result slot
   oic_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

`default_nettype wire

FILE: rtl/core/oic_checker.sv
// ---------------------------------------------------------------------------
// oic_checker
// Port-level checks of the island counter, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module oic_checker (
   input wire                      clock,
   input wire                      reset,
   input wire                      req_tvalid,
   input wire                      req_tready,
   input wire                      rsp_tvalid,
   input wire                      rsp_tready,
   input wire [oic_pkg::RSP_W-1:0] rsp_tdata
);
   import oic_pkg::*;

   `ASSERT_CLK_ALWAYS(a_sweep_after_reset, clock, reset |=> !req_tready)
   `ASSERT_CLK(a_one_query, clock, reset, (req_tvalid && req_tready) |=> !req_tready)
   `ASSERT_CLK(a_rsp_hold, clock, reset,
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
   `ASSERT_CLK(a_pad_zero, clock, reset, rsp_tvalid |-> (rsp_tdata[RSP_W-1:CNT_W+1] == '0))

endmodule

bind online_island_count_union_find oic_checker u_oic_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

FILE: verif/tb_top.sv
// ---------------------------------------------------------------------------
// Island counter testbench
// Drives cell queries into the union-find island counter under several grid
// settings. An in-bench union-find model predicts every response. Random
// gaps are applied on both stream sides.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import oic_pkg::*;

   localparam int NUM_RANDOM = 1330;

   // kinds of rows in the directed stimulus table
   typedef enum logic [1:0] {ROW_QUERY, ROW_SET_ROWS, ROW_SET_COLS} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [6:0]   arg_a;    // row, or register value
      logic [5:0]   arg_b;    // column
      bit           typed;    // expected response typed into the table
      int           want_count;
      bit           want_bad;
   } stim_row_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             bad;
   } island_rsp_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;

   online_island_count_union_find dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // ------------------------------------------------------------------
   // Island model: land map, parent links, ranks and the running count
   // ------------------------------------------------------------------
   bit  land_bits [CELLS];
   int  parent_of [CELLS];
   int  rank_of [CELLS];
   int  island_total;
   int  rows_reg;
   int  cols_reg;

   island_rsp_type pending_rsp [$];
   island_rsp_type last_want;         // prediction for the latest accepted query
   int             accepted = 0;      // queries accepted so far
   int             mismatches = 0;
   bit             idle_send = 1'b1;  // sender gaps enabled for this phase
   bit             idle_recv = 1'b1;  // receiver stalls enabled

   // Find the root and compress the walked path onto it.
   function automatic int find_root(int node);
      int top;
      int walk;
      int nxt;
      top = node;
      while (parent_of[top] != top) top = parent_of[top];
      walk = node;
      while (walk != top) begin
         nxt = parent_of[walk];
         parent_of[walk] = top;
         walk = nxt;
      end
      return top;
   endfunction

   // Union by rank; returns 1 when two separate trees were joined.
   function automatic bit merge_trees(int a, int b);
      int ra;
      int rb;
      ra = find_root(a);
      rb = find_root(b);
      if (ra == rb) return 1'b0;
      if (rank_of[ra] > rank_of[rb]) begin
         parent_of[rb] = ra;
      end else if (rank_of[rb] > rank_of[ra]) begin
         parent_of[ra] = rb;
      end else begin
         parent_of[rb] = ra;
         if (rank_of[ra] < 15) rank_of[ra]++;
      end
      return 1'b1;
   endfunction

   // Apply one query to the model and return the response it must produce.
   function automatic island_rsp_type predict_island(int row, int col);
      island_rsp_type r;
      int rows;
      int cols;
      int here;
      int nr;
      int nc;
      int dr [4] = '{0, 1, 0, -1};
      int dc [4] = '{1, 0, -1, 0};
      rows = (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
      cols = (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
      if (row >= rows || col >= cols) begin
         r.count = island_total[CNT_W-1:0];
         r.bad   = 1'b1;
         return r;
      end
      here = (row * cols + col) % CELLS;
      if (!land_bits[here]) begin
         land_bits[here] = 1'b1;
         if (island_total < 4095) island_total++;
         for (int k = 0; k < 4; k++) begin
            nr = row + dr[k];
            nc = col + dc[k];
            if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
            if (land_bits[(nr * cols + nc) % CELLS] &&
                merge_trees(here, (nr * cols + nc) % CELLS)) begin
               if (island_total > 0) island_total--;
            end
         end
      end
      r.count = island_total[CNT_W-1:0];
      r.bad   = 1'b0;
      return r;
   endfunction

   task automatic report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // Random gap: mostly none or short, a few long.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // ------------------------------------------------------------------
   // Clock, reset, watchdog
   // ------------------------------------------------------------------
   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // ------------------------------------------------------------------
   // Monitor: predict on each accepted request, check each response
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      island_rsp_type want;
      island_rsp_type got;
      if (!reset && req_tvalid && req_tready) begin
         last_want   = predict_island(int'(req_tdata[5:0]), int'(req_tdata[11:6]));
         pending_rsp = {pending_rsp, last_want};
         accepted++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.count = rsp_tdata[11:0];
         got.bad   = rsp_tdata[12];
         if (pending_rsp.size() == 0) begin
            report_mismatch("response with nothing outstanding");
         end else begin
            want = pending_rsp.pop_front();
            if (got.count !== want.count)
               report_mismatch($sformatf("island_count %0d, want %0d", got.count,
                                         want.count));
            if (got.bad !== want.bad)
               report_mismatch($sformatf("bad_coord %0b, want %0b", got.bad, want.bad));
         end
      end
   end

   // Receiver: alternate ready bursts and stalls; hold ready high when
   // stalls are switched off.
   initial begin
      int burst;
      int stall;
      forever begin
         burst = $urandom_range(1, 40);
         rsp_tready <= 1'b1;
         repeat (burst) @(posedge clock);
         stall = idle_recv ? gap_len() : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------
   // Driver helpers
   // ------------------------------------------------------------------
   // Present one query and hold it until the transaction completes.
   task automatic send_cell(int row, int col);
      int gap;
      req_tdata  <= {4'b0, col[5:0], row[5:0]};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      gap = idle_send ? gap_len() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every response is back, then settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == REG_GRID_ROWS) rows_reg = value;
      else cols_reg = value;
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   stim_row_type directed [] = '{
      '{ROW_QUERY,    7'd0,   6'd0,  1, 1, 0},  // first land cell
      '{ROW_QUERY,    7'd0,   6'd0,  1, 1, 0},  // already land
      '{ROW_QUERY,    7'd63,  6'd63, 1, 2, 0},  // far corner
      '{ROW_QUERY,    7'd0,   6'd63, 0, 0, 0},
      '{ROW_QUERY,    7'd63,  6'd0,  0, 0, 0},
      '{ROW_QUERY,    7'd0,   6'd1,  0, 0, 0},  // joins left neighbor
      '{ROW_QUERY,    7'd1,   6'd1,  0, 0, 0},
      '{ROW_QUERY,    7'd1,   6'd0,  0, 0, 0},  // closes a loop, roots equal
      '{ROW_QUERY,    7'd62,  6'd63, 0, 0, 0},
      '{ROW_QUERY,    7'd2,   6'd2,  0, 0, 0},
      '{ROW_QUERY,    7'd1,   6'd2,  0, 0, 0},  // bridges two islands
      '{ROW_SET_ROWS, 7'd5,   6'd0,  0, 0, 0},
      '{ROW_SET_COLS, 7'd4,   6'd0,  0, 0, 0},
      '{ROW_QUERY,    7'd5,   6'd0,  0, 0, 0},  // row out of grid
      '{ROW_QUERY,    7'd0,   6'd4,  0, 0, 0},  // column out of grid
      '{ROW_QUERY,    7'd4,   6'd3,  0, 0, 0},
      '{ROW_SET_ROWS, 7'd0,   6'd0,  0, 0, 0},
      '{ROW_QUERY,    7'd0,   6'd0,  0, 0, 0},  // zero grid: all outside
      '{ROW_SET_ROWS, 7'd127, 6'd0,  0, 0, 0},  // oversized acts as maximum
      '{ROW_SET_COLS, 7'd100, 6'd0,  0, 0, 0},
      '{ROW_QUERY,    7'd63,  6'd62, 0, 0, 0},
      '{ROW_SET_ROWS, 7'd3,   6'd0,  0, 0, 0},  // resize after use
      '{ROW_SET_COLS, 7'd3,   6'd0,  0, 0, 0},
      '{ROW_QUERY,    7'd1,   6'd1,  0, 0, 0},
      '{ROW_QUERY,    7'd2,   6'd2,  0, 0, 0}
   };

   initial begin
      int sent;
      int phase_len;
      int pick;
      int rows;
      int cols;
      int seen;
      island_rsp_type typed_rsp;

      for (int i = 0; i < CELLS; i++) begin
         land_bits[i] = 1'b0;
         parent_of[i] = i;
         rank_of[i]   = 1;
      end
      island_total = 0;
      rows_reg     = 64;
      cols_reg     = 64;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part; typed rows are checked against the table as well.
      foreach (directed[i]) begin
         case (directed[i].kind)
            ROW_SET_ROWS: begin
               drain();
               write_reg(REG_GRID_ROWS, directed[i].arg_a);
            end
            ROW_SET_COLS: begin
               drain();
               write_reg(REG_GRID_COLS, directed[i].arg_a);
            end
            default: begin
               seen = accepted;
               send_cell(directed[i].arg_a, directed[i].arg_b);
               if (directed[i].typed) begin
                  wait (accepted > seen);
                  typed_rsp = last_want;
                  if (typed_rsp.count != directed[i].want_count ||
                      typed_rsp.bad != directed[i].want_bad)
                     report_mismatch($sformatf("directed row %0d table value", i));
               end
            end
         endcase
      end

      // Random phases over a spread of grid settings.
      sent = 0;
      while (sent < NUM_RANDOM) begin
         drain();
         pick = $urandom_range(0, 9);
         case (pick)
            0: begin rows = 1;   cols = 1;   end
            1: begin rows = 64;  cols = 64;  end
            2: begin rows = 127; cols = $urandom_range(65, 127); end
            3: begin rows = 0;   cols = $urandom_range(0, 10);   end
            4: begin rows = $urandom_range(1, 64); cols = 1; end
            default: begin
               rows = $urandom_range(2, 12);
               cols = $urandom_range(2, 12);
            end
         endcase
         write_reg(REG_GRID_ROWS, CFG_W'(rows));
         write_reg(REG_GRID_COLS, CFG_W'(cols));
         idle_send = ($urandom_range(0, 3) != 0);
         idle_recv = ($urandom_range(0, 3) != 0);
         phase_len = $urandom_range(40, 150);
         rows = (rows > MAX_ROWS) ? MAX_ROWS : rows;
         cols = (cols > MAX_COLS) ? MAX_COLS : cols;
         for (int n = 0; n < phase_len && sent < NUM_RANDOM; n++) begin
            // mostly in-grid cells; some raw 6-bit coordinates
            if ($urandom_range(0, 9) == 0 || rows == 0 || cols == 0)
               send_cell($urandom_range(0, 63), $urandom_range(0, 63));
            else
               send_cell($urandom_range(0, rows - 1), $urandom_range(0, cols - 1));
            sent++;
         end
      end

      drain();
      repeat (40) @(posedge clock);
      if (pending_rsp.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", pending_rsp.size()));
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl/core
rtl/core/oic_pkg.sv
rtl/core/oic_ctrl.sv
rtl/core/oic_dp.sv
rtl/core/online_island_count_union_find.sv
rtl/core/oic_checker.sv
verif/tb_top.sv
